// ----- rtl/value_noise_3d_trilinear_core_assert.svh -----
// Assertion macros used by the checker file.
`ifndef VALUE_NOISE_3D_TRILINEAR_CORE_ASSERT_SVH
`define VALUE_NOISE_3D_TRILINEAR_CORE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define VN_ASSERT_IMPL(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define VN_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");
`endif

// ----- rtl/vn3d_pkg.sv -----
// Package with the shared types, constants and functions of the noise core.
package vn3d_pkg;
    localparam logic [63:0] HASH_MUL = 64'hff51afd7ed558ccd;
    localparam int unsigned CORNER_MOD = 1000;
    localparam logic [63:0] SEED_RESET = 64'd1;

    // Value field of an intermediate lerp or corner, Q0.16.
    typedef logic [15:0] t_val;

    // Reduce a 16-bit chunk mod 1000; the hash later scales the residue to Q0.16.
    // h mod 1000 is done from 16-bit chunk residues; 2^16 mod 1000 = 536.
    // The reciprocal rounds down, so the quotient is low by at most one.
    function automatic logic [9:0] mod1000_chunk(input logic [15:0] v);
        logic [15:0] q;
        logic [31:0] p;
        logic [16:0] r;
        begin
            p = 32'(v) * 32'd4194;          // floor(2^22/1000) = 4194
            q = 16'(p >> 22);
            r = 17'(v) - 17'(q) * 17'(CORNER_MOD);
            if (r >= 17'(CORNER_MOD)) r = r - 17'(CORNER_MOD);
            mod1000_chunk = r[9:0];
        end
    endfunction

    // Residue mod 1000 of a 21-bit sum, same scheme with floor(2^30/1000).
    function automatic logic [9:0] mod1000_wide(input logic [20:0] x);
        logic [41:0] p;
        logic [11:0] q;
        logic [21:0] r;
        begin
            p = 42'(x) * 42'd1073741;
            q = 12'(p >> 30);
            r = 22'(x) - 22'(q) * 22'(CORNER_MOD);
            if (r >= 22'(CORNER_MOD)) r = r - 22'(CORNER_MOD);
            mod1000_wide = r[9:0];
        end
    endfunction
endpackage

// ----- rtl/vn3d_stream_if.sv -----
// Valid/ready stream interface carrying a payload.
interface vn3d_stream_if #(parameter int unsigned W = 96);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/vn3d_hash.sv -----
// Corner hash pipeline: mix, multiply in partial products, reduce to Q0.16.
module vn3d_hash
    import vn3d_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    input  logic [63:0] i_s,
    output t_val        o_val
);
    logic [63:0] n_h, r_h;
    logic [63:0] r_p0, r_p1, r_p2;
    logic [63:0] r_m;
    logic [9:0]  r_c0, r_c1, r_c2, r_c3;
    logic [20:0] r_sum;
    logic [9:0]  n_r;
    logic [25:0] r_sc;
    t_val        r_val;

    always_comb begin
        n_h = (i_a ^ i_s) ^ (i_b ^ (i_s >> 32));
        n_h = n_h ^ (n_h >> 33);
    end

    // Low 64 bits of h*K from three 32x32 partial products.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_h  <= n_h;
            r_p0 <= 64'(r_h[31:0])  * 64'(HASH_MUL[31:0]);
            r_p1 <= 64'(r_h[63:32]) * 64'(HASH_MUL[31:0]);
            r_p2 <= 64'(r_h[31:0])  * 64'(HASH_MUL[63:32]);
            r_m  <= r_p0 + {r_p1[31:0] + r_p2[31:0], 32'd0};
        end
    end

    logic [63:0] w_g;
    assign w_g = r_m ^ (r_m >> 33);

    assign n_r = mod1000_wide(r_sum);

    // Chunk residues weighted by 2^(16k) mod 1000: 1, 536, 296, 656.
    // The scale by 65536/1000 uses a reciprocal that rounds up by less than
    // the gap to the next integer, so the floor is exact.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c0  <= mod1000_chunk(w_g[15:0]);
            r_c1  <= mod1000_chunk(w_g[31:16]);
            r_c2  <= mod1000_chunk(w_g[47:32]);
            r_c3  <= mod1000_chunk(w_g[63:48]);
            r_sum <= 21'(r_c0) + 21'(r_c1) * 21'd536 + 21'(r_c2) * 21'd296
                   + 21'(r_c3) * 21'd656;
            r_sc  <= 26'(n_r) * 26'd65536;
            r_val <= 16'((57'(r_sc) * 57'd1099511628) >> 40);
        end
    end
    assign o_val = r_val;
endmodule

// ----- rtl/vn3d_lerp.sv -----
// One registered lerp stage.
module vn3d_lerp
    import vn3d_pkg::*;
#(parameter int unsigned FB = 16)
(
    input  logic        i_clk,
    input  logic        i_en,
    input  t_val        i_a,
    input  t_val        i_b,
    input  logic [FB-1:0] i_s,
    output t_val        o_y
);
    localparam int unsigned PW = FB + 17;
    logic [FB:0] w_one;
    t_val r_y;
    assign w_one = (FB+1)'(1) << FB;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y <= 16'(((PW'(i_a) * PW'(w_one - (FB+1)'(i_s)))
                      + (PW'(i_b) * PW'(i_s))) >> FB);
        end
    end
    assign o_y = r_y;
endmodule

// ----- rtl/value_noise_3d_trilinear_core.sv -----
// Top level of the pipelined 3D value noise core.
// One beat in, one beat out, a new point every cycle while the output is not
// stalled; the lockstep pipeline holds the hash in seven stages, then three
// lerp stages, and a stall of the output freezes the whole pipeline.
// The user writes the seed register through i_cfg_we/i_cfg_data only while idle; the core does not enforce it.
module value_noise_3d_trilinear_core
    import vn3d_pkg::*;
#(parameter int unsigned FRAC_BITS = 16)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [63:0] i_cfg_data,
    vn3d_stream_if.sink   in_if,
    vn3d_stream_if.source out_if
);
    localparam int unsigned HL  = 7;
    localparam int unsigned LAT = HL + 3;
    localparam int unsigned FB  = FRAC_BITS;

    logic [63:0] r_seed;
    logic [LAT-1:0] r_vld;
    logic w_en;

    // The pipeline moves when its last stage is empty or being drained.
    assign w_en = !r_vld[LAT-1] || out_if.ready;
    assign in_if.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= SEED_RESET;
            r_vld  <= '0;
        end else begin
            if (i_cfg_we) r_seed <= i_cfg_data;
            if (w_en) r_vld <= {r_vld[LAT-2:0], in_if.valid};
        end
    end

    logic signed [31:0] w_cx, w_cy, w_cz;
    assign w_cx = in_if.data[31:0];
    assign w_cy = in_if.data[63:32];
    assign w_cz = in_if.data[95:64];

    logic [63:0] w_x0, w_y0, w_z0, w_x1, w_y1, w_s0, w_s1;
    assign w_x0 = 64'(w_cx >>> FB);
    assign w_y0 = 64'(w_cy >>> FB);
    assign w_z0 = 64'(w_cz >>> FB);
    assign w_x1 = w_x0 + 64'd1;
    assign w_y1 = w_y0 + 64'd1;
    assign w_s0 = w_z0 + r_seed;
    assign w_s1 = w_z0 + 64'd1 + r_seed;

    // Smoothstep weights, carried alongside the hash stages. Entry k of r_w
    // holds the weight of the item in stage 3+k, so entry HL-3 lines up with
    // the corner values leaving the hash.
    logic [FB-1:0] r_f [3];
    logic [FB-1:0] r_f2 [3];
    logic [FB+1:0] r_t [3];
    logic [FB-1:0] r_w [3][HL-2];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f[0] <= w_cx[FB-1:0];
            r_f[1] <= w_cy[FB-1:0];
            r_f[2] <= w_cz[FB-1:0];
            for (int i = 0; i < 3; i++) begin
                r_f2[i] <= FB'((2*FB)'(r_f[i]) * (2*FB)'(r_f[i]) >> FB);
                r_t[i]  <= (FB+2)'(3) * ((FB+2)'(1) << FB) - ((FB+2)'(r_f[i]) << 1);
                r_w[i][0] <= FB'(((2*FB+2)'(r_f2[i]) * (2*FB+2)'(r_t[i])) >> FB);
                for (int k = 1; k < HL-2; k++) r_w[i][k] <= r_w[i][k-1];
            end
        end
    end

    t_val w_c [8];
    for (genvar g = 0; g < 8; g++) begin : g_corner
        vn3d_hash u_hash (
            .i_clk (i_clk), .i_en (w_en),
            .i_a   (((g & 1) != 0) ? w_x1 : w_x0),
            .i_b   (((g & 2) != 0) ? w_y1 : w_y0),
            .i_s   (((g & 4) != 0) ? w_s1 : w_s0),
            .o_val (w_c[g])
        );
    end

    logic [FB-1:0] r_v1, r_w1, r_w2;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_v1 <= r_w[1][HL-3];
            r_w1 <= r_w[2][HL-3];
            r_w2 <= r_w1;
        end
    end

    t_val w_l [4];
    t_val w_m [2];
    t_val w_o;
    for (genvar g = 0; g < 4; g++) begin : g_lx
        vn3d_lerp #(.FB(FB)) u_lx (.i_clk(i_clk), .i_en(w_en), .i_a(w_c[2*g]),
            .i_b(w_c[2*g+1]), .i_s(r_w[0][HL-3]), .o_y(w_l[g]));
    end
    for (genvar g = 0; g < 2; g++) begin : g_ly
        vn3d_lerp #(.FB(FB)) u_ly (.i_clk(i_clk), .i_en(w_en), .i_a(w_l[2*g]),
            .i_b(w_l[2*g+1]), .i_s(r_v1), .o_y(w_m[g]));
    end
    vn3d_lerp #(.FB(FB)) u_lz (.i_clk(i_clk), .i_en(w_en), .i_a(w_m[0]),
        .i_b(w_m[1]), .i_s(r_w2), .o_y(w_o));

    assign out_if.valid = r_vld[LAT-1];
    assign out_if.data  = w_o;
endmodule

// ----- rtl/vn3d_checker.sv -----
// Port-level checker for the noise core and its bind.
`include "value_noise_3d_trilinear_core_assert.svh"
module vn3d_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic [15:0] i_out_data
);
    `VN_ASSERT_NEXT(a_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `VN_ASSERT_NEXT(a_data, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_out_data))
    `VN_ASSERT_IMPL(a_rdy, i_clk, i_rst_n, !i_out_valid, i_in_ready)
    `VN_ASSERT_IMPL(a_stall, i_clk, i_rst_n, i_out_valid && !i_out_ready, !i_in_ready)
endmodule

bind value_noise_3d_trilinear_core vn3d_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_in_valid(in_if.valid), .i_in_ready(in_if.ready),
    .i_out_valid(out_if.valid), .i_out_ready(out_if.ready),
    .i_out_data(out_if.data[15:0])
);
